// ===== design/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants, codes and helpers for the bitmap page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

    localparam int DEF_MAX_PAGES      = 32768;
    localparam int DEF_PAGE_BYTES     = 4096;
    localparam int DEF_RESERVED_PAGES = 256;

    localparam int WORD_W = 32;
    localparam int MB_W   = 12;
    localparam int CMD_W  = 2;
    localparam int STS_W  = 2;
    localparam int ADDR_W = 27;
    localparam int CNT_W  = 16;
    localparam int FA_W   = 32;

    localparam logic [MB_W-1:0] MB_RESET = 12'd128;

    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REINIT = 2'd2;

    localparam logic [STS_W-1:0] STS_OK      = 2'd0;
    localparam logic [STS_W-1:0] STS_OOM     = 2'd1;
    localparam logic [STS_W-1:0] STS_IGNORED = 2'd2;
    localparam logic [STS_W-1:0] STS_REINIT  = 2'd3;

    typedef logic [WORD_W-1:0] t_word;

    // index of the lowest clear bit, zero when all bits are set
    function automatic logic [4:0] lowest_zero(input t_word w);
        logic [4:0] idx;
        idx = 5'd0;
        for (int k = WORD_W - 1; k >= 0; k--) begin
            if (!w[k]) begin
                idx = 5'(k);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ===== design/bpa_ram.sv =====
// ----------------------------------------------------------------------------
// bpa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/bitmap_page_allocator_core.sv =====
// ----------------------------------------------------------------------------
// bitmap_page_allocator_core
// First-fit page frame allocator over a one-bit-per-page map in RAM.
// ----------------------------------------------------------------------------
// Requests enter on i_in_valid / o_in_stall with a command and a free
// address; one result per request leaves on o_out_valid / i_out_stall.
// i_cfg_we writes the installed memory size in megabytes; the managed page
// count follows from it at once.
// The map is kept as 32-bit words in a RAM, with a second RAM holding one
// "word full" bit per map word. Allocate scans the summary RAM one word per
// cycle (SUM_WORDS = 32 words at default size), then reads and updates one
// map word. Free of a managed page reads both RAMs once. Reinit sweeps every
// map word once. One request is in flight at a time; o_in_stall is high
// while busy. After reset the same sweep clears the map and reserves the low
// pages, with o_in_stall high.
// A finished result sits in an output register; while i_out_stall is high
// and that register is full, the next result waits and no request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_page_allocator_core
    import bpa_pkg::*;
#(
    parameter int MAX_PAGES      = DEF_MAX_PAGES,
    parameter int PAGE_BYTES     = DEF_PAGE_BYTES,
    parameter int RESERVED_PAGES = DEF_RESERVED_PAGES
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [MB_W-1:0]   i_cfg_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [CMD_W-1:0]  i_command,
    input  wire logic [FA_W-1:0]   i_free_address,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic      [STS_W-1:0]  o_status,
    output logic      [ADDR_W-1:0] o_page_address,
    output logic      [CNT_W-1:0]  o_used_count,
    output logic      [CNT_W-1:0]  o_total_count
);

    localparam int PB_SHIFT  = $clog2(PAGE_BYTES);
    localparam int MB_SHIFT  = 20 - PB_SHIFT;
    localparam int MAP_WORDS = (MAX_PAGES + WORD_W - 1) / WORD_W;
    localparam int SUM_WORDS = (MAP_WORDS + WORD_W - 1) / WORD_W;
    localparam int MAP_AW    = $clog2(MAP_WORDS);
    localparam int SUM_AW    = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
    localparam int CLR_W     = SUM_AW + 5;
    localparam int PG_W      = SUM_AW + 10;
    localparam int UC_W      = $clog2(MAX_PAGES + 1);
    localparam int RAW_W     = MB_W + MB_SHIFT;
    localparam int RES_FULLW = RESERVED_PAGES / WORD_W;
    localparam t_word RES_PART = t_word'((64'd1 << (RESERVED_PAGES % WORD_W)) - 64'd1);
    localparam logic [CLR_W-1:0]  CLR_LAST = CLR_W'(SUM_WORDS * WORD_W - 1);
    localparam logic [SUM_AW-1:0] SUM_LAST = SUM_AW'(SUM_WORDS - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_ALLOC = 3'd3;
    localparam logic [2:0] S_FREE  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [CLR_W-1:0]  r_cidx, n_cidx;
    t_word             r_acc, n_acc;
    logic              r_rsp, n_rsp;
    logic [SUM_AW-1:0] r_sidx, n_sidx;
    t_word             r_sword, n_sword;
    logic [CLR_W-1:0]  r_wsel, n_wsel;
    logic [PG_W-1:0]   r_fidx, n_fidx;
    logic [UC_W-1:0]   r_used, n_used;
    logic [STS_W-1:0]  r_status, n_status;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [MB_W-1:0]   r_mb;

    logic              r_out_valid;
    logic [STS_W-1:0]  r_out_status;
    logic [ADDR_W-1:0] r_out_addr;
    logic [CNT_W-1:0]  r_out_used;
    logic [CNT_W-1:0]  r_out_total;

    logic              map_we, map_re, sum_we, sum_re;
    logic [MAP_AW-1:0] map_waddr, map_raddr;
    logic [SUM_AW-1:0] sum_waddr, sum_raddr;
    t_word             map_wdata, sum_wdata, w_mrd, w_srd;

    logic [RAW_W-1:0]  w_raw;
    logic [UC_W-1:0]   w_total;
    logic [FA_W-1:0]   w_fidx;
    logic              w_accept, w_out_free, w_load;
    t_word             w_clr_mask, w_new;
    logic              w_clr_full;
    logic [4:0]        w_j, w_b;
    logic [CLR_W-1:0]  w_wsel;
    logic [PG_W-1:0]   w_pidx;

    // managed page count
    assign w_raw   = RAW_W'(r_mb) << MB_SHIFT;
    assign w_total = (32'(w_raw) > 32'(MAX_PAGES)) ? UC_W'(MAX_PAGES) : UC_W'(w_raw);

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_load     = (r_state == S_DONE) && w_out_free;
    assign w_fidx     = i_free_address >> PB_SHIFT;

    // reserved pattern for the word under the clearing sweep
    always_comb begin
        if (32'(r_cidx) < 32'(RES_FULLW)) begin
            w_clr_mask = '1;
        end else if (32'(r_cidx) == 32'(RES_FULLW)) begin
            w_clr_mask = RES_PART;
        end else begin
            w_clr_mask = '0;
        end
        w_clr_full = (32'(r_cidx) < 32'(MAP_WORDS)) ? (w_clr_mask == '1) : 1'b1;
    end

    assign w_j    = lowest_zero(w_srd);
    assign w_wsel = {r_sidx, w_j};
    assign w_b    = lowest_zero(w_mrd);
    assign w_pidx = {r_wsel, w_b};
    assign w_new  = w_mrd | (t_word'(1) << w_b);

    always_comb begin
        n_state  = r_state;
        n_cidx   = r_cidx;
        n_acc    = r_acc;
        n_rsp    = r_rsp;
        n_sidx   = r_sidx;
        n_sword  = r_sword;
        n_wsel   = r_wsel;
        n_fidx   = r_fidx;
        n_used   = r_used;
        n_status = r_status;
        n_addr   = r_addr;

        map_we    = 1'b0;
        map_waddr = '0;
        map_wdata = '0;
        map_re    = 1'b0;
        map_raddr = '0;
        sum_we    = 1'b0;
        sum_waddr = '0;
        sum_wdata = '0;
        sum_re    = 1'b0;
        sum_raddr = '0;

        case (r_state)
            S_CLEAR: begin
                map_we    = (32'(r_cidx) < 32'(MAP_WORDS));
                map_waddr = r_cidx[MAP_AW-1:0];
                map_wdata = w_clr_mask;
                n_acc     = {w_clr_full, r_acc[WORD_W-1:1]};
                if (r_cidx[4:0] == 5'd31 || r_cidx == CLR_LAST) begin
                    sum_we    = 1'b1;
                    sum_waddr = r_cidx[5 +: SUM_AW];
                    sum_wdata = {w_clr_full, r_acc[WORD_W-1:1]};
                end
                if (r_cidx == CLR_LAST) begin
                    n_state = r_rsp ? S_DONE : S_IDLE;
                    n_rsp   = 1'b0;
                end else begin
                    n_cidx = r_cidx + CLR_W'(1);
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_status = STS_IGNORED;
                    n_addr   = '0;
                    case (i_command)
                        CMD_ALLOC: begin
                            sum_re    = 1'b1;
                            sum_raddr = '0;
                            n_sidx    = '0;
                            n_state   = S_SCAN;
                        end
                        CMD_FREE: begin
                            if (w_fidx < 32'(w_total)) begin
                                map_re    = 1'b1;
                                map_raddr = w_fidx[5 +: MAP_AW];
                                sum_re    = 1'b1;
                                sum_raddr = w_fidx[10 +: SUM_AW];
                                n_fidx    = w_fidx[PG_W-1:0];
                                n_state   = S_FREE;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        CMD_REINIT: begin
                            n_used   = UC_W'(RESERVED_PAGES);
                            n_cidx   = '0;
                            n_rsp    = 1'b1;
                            n_status = STS_REINIT;
                            n_state  = S_CLEAR;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (w_srd != '1) begin
                    if (32'({w_wsel, 5'd0}) >= 32'(w_total)) begin
                        n_status = STS_OOM;
                        n_state  = S_DONE;
                    end else begin
                        map_re    = 1'b1;
                        map_raddr = w_wsel[MAP_AW-1:0];
                        n_wsel    = w_wsel;
                        n_sword   = w_srd;
                        n_state   = S_ALLOC;
                    end
                end else if (r_sidx == SUM_LAST) begin
                    n_status = STS_OOM;
                    n_state  = S_DONE;
                end else begin
                    sum_re    = 1'b1;
                    sum_raddr = r_sidx + SUM_AW'(1);
                    n_sidx    = r_sidx + SUM_AW'(1);
                end
            end
            S_ALLOC: begin
                if (32'(w_pidx) >= 32'(w_total)) begin
                    n_status = STS_OOM;
                end else begin
                    map_we    = 1'b1;
                    map_waddr = r_wsel[MAP_AW-1:0];
                    map_wdata = w_new;
                    if (w_new == '1) begin
                        sum_we    = 1'b1;
                        sum_waddr = r_sidx;
                        sum_wdata = r_sword | (t_word'(1) << r_wsel[4:0]);
                    end
                    n_used   = r_used + UC_W'(1);
                    n_status = STS_OK;
                    n_addr   = ADDR_W'(w_pidx) << PB_SHIFT;
                end
                n_state = S_DONE;
            end
            S_FREE: begin
                if (w_mrd[r_fidx[4:0]]) begin
                    map_we    = 1'b1;
                    map_waddr = r_fidx[5 +: MAP_AW];
                    map_wdata = w_mrd & ~(t_word'(1) << r_fidx[4:0]);
                    sum_we    = 1'b1;
                    sum_waddr = r_fidx[10 +: SUM_AW];
                    sum_wdata = w_srd & ~(t_word'(1) << r_fidx[9:5]);
                    if (r_used != '0) begin
                        n_used = r_used - UC_W'(1);
                    end
                    n_status = STS_OK;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cidx      <= '0;
            r_rsp       <= 1'b0;
            r_used      <= UC_W'(RESERVED_PAGES);
            r_mb        <= MB_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cidx  <= n_cidx;
            r_rsp   <= n_rsp;
            r_used  <= n_used;
            if (i_cfg_we) begin
                r_mb <= i_cfg_data;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_sidx   <= n_sidx;
        r_sword  <= n_sword;
        r_wsel   <= n_wsel;
        r_fidx   <= n_fidx;
        r_status <= n_status;
        r_addr   <= n_addr;
        if (w_load) begin
            r_out_status <= r_status;
            r_out_addr   <= r_addr;
            r_out_used   <= CNT_W'(r_used);
            r_out_total  <= CNT_W'(w_total);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_page_address = r_out_addr;
    assign o_used_count   = r_out_used;
    assign o_total_count  = r_out_total;

    bpa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAP_WORDS),
        .AW    (MAP_AW)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (map_re),
        .i_raddr (map_raddr),
        .o_rdata (w_mrd)
    );

    bpa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SUM_WORDS),
        .AW    (SUM_AW)
    ) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (sum_waddr),
        .i_wdata (sum_wdata),
        .i_re    (sum_re),
        .i_raddr (sum_raddr),
        .o_rdata (w_srd)
    );

endmodule

`default_nettype wire

// ===== verif/tb_bitmap_page_allocator_core.sv =====
// ----------------------------------------------------------------------------
// tb_bitmap_page_allocator_core
// Self-checking bench for the first-fit bitmap page allocator.
// ----------------------------------------------------------------------------
// A queue of pending requests feeds a driver that presents one request at a
// time on the input channel. A monitor predicts each accepted request against
// its own copy of the page map, used count and memory size, and compares every
// result leaving the block with the oldest prediction. The run steps through
// several memory sizes (zero, one and two megabytes, the reset size, a random
// size and the largest), covering out of memory, ignored frees, undefined
// commands and reinit with more reserved pages than managed ones. Both sides
// idle at random, one phase runs with no idling, and once the receiver holds
// off long enough for the block to stall its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bitmap_page_allocator_core;
    import bpa_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNDEFINED = 2'd3;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_PERCENT = 13;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [FA_W-1:0]  addr;
    } t_request;

    typedef struct {
        logic [STS_W-1:0]  status;
        logic [ADDR_W-1:0] page_address;
        logic [CNT_W-1:0]  used;
        logic [CNT_W-1:0]  total;
    } t_alloc_result;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_cfg_we       = 1'b0;
    logic [MB_W-1:0]   i_cfg_data     = '0;
    logic              i_in_valid     = 1'b0;
    logic [CMD_W-1:0]  i_command      = CMD_ALLOC;
    logic [FA_W-1:0]   i_free_address = '0;
    logic              i_out_stall    = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [STS_W-1:0]  o_status;
    logic [ADDR_W-1:0] o_page_address;
    logic [CNT_W-1:0]  o_used_count;
    logic [CNT_W-1:0]  o_total_count;

    // allocator state as predicted
    bit              page_busy [DEF_MAX_PAGES];
    int unsigned     pages_in_use;
    logic [MB_W-1:0] megabytes;

    t_request      pending_requests [$];
    t_alloc_result expected_results [$];
    t_request      next_request;
    t_alloc_result want;

    logic req_taken  = 1'b0;
    logic quiet      = 1'b0;
    logic hold_req   = 1'b0;
    logic hold_ack   = 1'b0;
    int   hold_left  = 0;
    int   mismatch_count = 0;
    int   cycle_count    = 0;

    bitmap_page_allocator_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_free_address (i_free_address),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_page_address (o_page_address),
        .o_used_count   (o_used_count),
        .o_total_count  (o_total_count)
    );

    always #1 i_clk = ~i_clk;

    function automatic int unsigned managed_page_count();
        longint unsigned pages;
        pages = longint'(megabytes) * 64'd1048576 / DEF_PAGE_BYTES;
        if (pages > DEF_MAX_PAGES) begin
            pages = DEF_MAX_PAGES;
        end
        return int'(pages);
    endfunction

    function automatic void reserve_low_pages();
        foreach (page_busy[k]) begin
            page_busy[k] = (k < DEF_RESERVED_PAGES);
        end
        pages_in_use = (DEF_RESERVED_PAGES < DEF_MAX_PAGES) ? DEF_RESERVED_PAGES
                                                            : DEF_MAX_PAGES;
    endfunction

    function automatic t_alloc_result apply_request(input t_request r);
        t_alloc_result res;
        int unsigned   total;
        int unsigned   idx;
        total = managed_page_count();
        res.status = STS_IGNORED;
        res.page_address = '0;
        case (r.cmd)
            CMD_ALLOC: begin
                res.status = STS_OOM;
                for (int unsigned i = 0; i < total; i++) begin
                    if (!page_busy[i]) begin
                        page_busy[i] = 1'b1;
                        pages_in_use++;
                        res.page_address = ADDR_W'(i * DEF_PAGE_BYTES);
                        res.status = STS_OK;
                        break;
                    end
                end
            end
            CMD_FREE: begin
                idx = r.addr / DEF_PAGE_BYTES;
                if (idx < total && page_busy[idx]) begin
                    page_busy[idx] = 1'b0;
                    if (pages_in_use > 0) begin
                        pages_in_use--;
                    end
                    res.status = STS_OK;
                end
            end
            CMD_REINIT: begin
                reserve_low_pages();
                res.status = STS_REINIT;
            end
            default: res.status = STS_IGNORED;
        endcase
        res.used  = CNT_W'(pages_in_use);
        res.total = CNT_W'(total);
        return res;
    endfunction

    // monitor: config tracking, result checking, prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_taken <= 1'b0;
            megabytes = MB_RESET;
            reserve_low_pages();
        end else begin
            if (i_cfg_we) begin
                megabytes = i_cfg_data;
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding: status %0d", o_status);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_status !== want.status) begin
                        $error("status expected %0d got %0d", want.status, o_status);
                        mismatch_count++;
                    end
                    if (o_page_address !== want.page_address) begin
                        $error("page_address expected 0x%0h got 0x%0h",
                               want.page_address, o_page_address);
                        mismatch_count++;
                    end
                    if (o_used_count !== want.used) begin
                        $error("used_count expected %0d got %0d", want.used, o_used_count);
                        mismatch_count++;
                    end
                    if (o_total_count !== want.total) begin
                        $error("total_count expected %0d got %0d",
                               want.total, o_total_count);
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(
                    apply_request('{cmd: i_command, addr: i_free_address}));
                req_taken <= 1'b1;
            end else begin
                req_taken <= 1'b0;
            end
        end
    end

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || req_taken) begin
            if (pending_requests.size() != 0
                && (quiet || $urandom_range(99) >= IDLE_PERCENT)) begin
                next_request = pending_requests.pop_front();
                i_in_valid     <= 1'b1;
                i_command      <= next_request.cmd;
                i_free_address <= next_request.addr;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack    <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("bitmap_page_allocator_core verification failed");
            $finish;
        end
    end

    task automatic queue_request(input logic [CMD_W-1:0] cmd, input logic [FA_W-1:0] addr);
        pending_requests.push_back('{cmd: cmd, addr: addr});
    endtask

    function automatic logic [FA_W-1:0] page_addr(input int unsigned idx);
        return FA_W'(idx * DEF_PAGE_BYTES);
    endfunction

    task automatic drain_and_configure(input logic [MB_W-1:0] mb);
        while (pending_requests.size() != 0 || i_in_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= mb;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // mostly allocate and free of pages near the low end, with wild addresses,
    // undefined commands and the odd reinit mixed in
    task automatic queue_random(input int count, input int alloc_pct, input int free_span);
        int roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < 2) begin
                queue_request(CMD_REINIT, $urandom);
            end else if (roll < 4) begin
                queue_request(CMD_UNDEFINED, $urandom);
            end else if (roll < 4 + alloc_pct) begin
                queue_request(CMD_ALLOC, $urandom);
            end else if ($urandom_range(9) == 0) begin
                queue_request(CMD_FREE, $urandom);
            end else begin
                queue_request(CMD_FREE, page_addr($urandom_range(free_span - 1))
                                        + $urandom_range(DEF_PAGE_BYTES - 1));
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // one megabyte: every managed page is reserved
        drain_and_configure(12'd1);
        queue_request(CMD_ALLOC, 32'h0);
        queue_request(CMD_FREE, 32'h0);
        queue_request(CMD_ALLOC, 32'hFFFF_FFFF);
        queue_request(CMD_FREE, 32'hFFFF_FFFF);
        queue_request(CMD_FREE, page_addr(256));
        queue_request(CMD_FREE, page_addr(255) + 32'hFFF);
        queue_request(CMD_FREE, page_addr(255));
        queue_request(CMD_UNDEFINED, 32'hFFFF_FFFF);
        queue_request(CMD_REINIT, 32'h0);
        queue_request(CMD_ALLOC, 32'h0);

        // no memory at all, reinit still reserves the low pages
        drain_and_configure(12'd0);
        queue_request(CMD_ALLOC, 32'h0);
        queue_request(CMD_FREE, 32'h0);
        queue_request(CMD_REINIT, 32'hFFFF_FFFF);

        // largest size, clamped page count
        drain_and_configure(12'd4095);
        queue_request(CMD_ALLOC, 32'h0);
        queue_request(CMD_FREE, page_addr(32767));
        queue_request(CMD_FREE, 32'h7FFF_FFFF);
        queue_request(CMD_ALLOC, 32'h0);
        queue_request(CMD_ALLOC, 32'h0);
        queue_request(CMD_FREE, page_addr(256));
        queue_request(CMD_ALLOC, 32'h0);

        drain_and_configure(12'd1);
        queue_random(150, 45, 264);

        drain_and_configure(12'd2);
        queue_random(150, 70, 520);

        // receiver holds off while requests keep coming
        drain_and_configure(MB_RESET);
        hold_req <= ~hold_req;
        queue_random(100, 60, 300);

        drain_and_configure(MB_W'($urandom_range(4094, 3)));
        quiet <= 1'b1;
        queue_random(120, 60, 320);

        drain_and_configure(12'd4095);
        quiet <= 1'b0;
        queue_random(80, 60, 320);

        while (pending_requests.size() != 0 || i_in_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (64) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("bitmap_page_allocator_core verification clean");
        end else begin
            $display("bitmap_page_allocator_core verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
